FILE: rtl/ibma_pkg.sv
// Package for the indirect block map allocator: sizes, codes, state type
// and the bit search helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ibma_pkg;

  localparam int MAX_BLOCKS   = 4096;
  localparam int PTRS_PER_BLK = 16;
  localparam int DIRECT_SLOTS = 12;
  localparam int INODE_SLOTS  = DIRECT_SLOTS + 3;
  localparam int MAP_CAP      = DIRECT_SLOTS + PTRS_PER_BLK + PTRS_PER_BLK * PTRS_PER_BLK
                                + PTRS_PER_BLK * PTRS_PER_BLK * PTRS_PER_BLK;

  localparam int BLK_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = BLK_W + 1;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int ROWS    = MAX_BLOCKS / WORD_W;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int DIG_W   = $clog2(PTRS_PER_BLK);
  localparam int STORE_D = MAX_BLOCKS * PTRS_PER_BLK;
  localparam int SADDR_W = $clog2(STORE_D);
  localparam int OFF_W   = 3 * DIG_W;
  localparam int SLOT_W  = $clog2(INODE_SLOTS);

  localparam logic [CNT_W-1:0] EMPTY_MARK = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_NEW  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_MARK = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_MAP_FULL = 2'd2,
    ST_BAD_PRELOAD = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_ALLOC_RD,
    S_MAP,
    S_WCHK,
    S_FILL,
    S_LINK,
    S_WNEXT,
    S_FINAL,
    S_MARK_RD,
    S_DONE
  } state_t;

  // lowest clear bit of a word: {found, index}
  function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W:0] res;
    res = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        res = {1'b1, BIT_W'(i)};
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ibma_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ibma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/indirect_block_map_allocator.sv
// Indirect block map allocator: top level with bitmap and pointer store.
// Depends on ibma_pkg and ibma_ram.
//
// Usage:
//   in_*  : one beat per command; tuser carries the action, tdata the block
//           index for a preload. Accepted only while no command is in work.
//   out_* : one result beat per command, held in an output register until
//           taken; the next command is accepted while it waits.
//   cfg_* : writes blocks_in_use and reloads the free count; always ready,
//           to be used only between commands.
// An indirect append walks each level of its map and takes a pointer block
// where one is missing on the way (one bitmap read-modify-write, then a
// 16-entry fill of the pointer store). The longest command is a triple
// indirect append that takes three pointer blocks.
// The bitmap search reads one 64-bit row: per-row full flags pick the row.
// Reset clears row valid flags at once, so no clearing pass is needed.
// A stalled receiver holds the result; a finished command then waits.
`timescale 1ns / 1ps
`default_nettype none
module indirect_block_map_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // block_index[11:0], zero pad
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // data_block[11:0], logical_number[24:12],
                                       // free_blocks[37:25], zero pad
  output logic      [1:0]  out_tuser,  // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data    // blocks_in_use[12:0]
);

  localparam int BLK_W   = ibma_pkg::BLK_W;
  localparam int CNT_W   = ibma_pkg::CNT_W;
  localparam int WORD_W  = ibma_pkg::WORD_W;
  localparam int BIT_W   = ibma_pkg::BIT_W;
  localparam int ROWS    = ibma_pkg::ROWS;
  localparam int ROW_W   = ibma_pkg::ROW_W;
  localparam int DIG_W   = ibma_pkg::DIG_W;
  localparam int SADDR_W = ibma_pkg::SADDR_W;
  localparam int OFF_W   = ibma_pkg::OFF_W;
  localparam int SLOT_W  = ibma_pkg::SLOT_W;
  localparam int NSLOT   = ibma_pkg::INODE_SLOTS;
  localparam int PPB     = ibma_pkg::PTRS_PER_BLK;
  localparam int DIRECT  = ibma_pkg::DIRECT_SLOTS;

  ibma_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  span_r, span_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic [CNT_W-1:0]  slot_r [NSLOT];
  logic [CNT_W-1:0]  slot_nxt [NSLOT];
  logic [ROWS-1:0]   rvalid_r, rvalid_nxt;
  logic [ROWS-1:0]   rfull_r, rfull_nxt;

  logic              ret_ptr_r, ret_ptr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [BIT_W-1:0]  mbit_r, mbit_nxt;
  logic [BLK_W-1:0]  got_r, got_nxt;
  logic [BLK_W-1:0]  data_r, data_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [1:0]        lvl_r, lvl_nxt;
  logic [1:0]        dep_r, dep_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              src_st_r, src_st_nxt;
  logic [SADDR_W-1:0] ent_r, ent_nxt;
  logic [DIG_W-1:0]  cnt_r, cnt_nxt;

  logic [1:0]        rst_status_r, rst_status_nxt;
  logic [BLK_W-1:0]  rdata_blk_r, rdata_blk_nxt;
  logic [CNT_W-1:0]  rlnum_r, rlnum_nxt;

  logic              ov_r, ov_nxt;
  logic [BLK_W-1:0]  o_data_r, o_data_nxt;
  logic [CNT_W-1:0]  o_lnum_r, o_lnum_nxt;
  logic [CNT_W-1:0]  o_free_r, o_free_nxt;
  logic [1:0]        o_stat_r, o_stat_nxt;

  // bitmap ram
  logic              bm_we, bm_re;
  logic [ROW_W-1:0]  bm_waddr, bm_raddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  // pointer store
  logic               ps_we, ps_re;
  logic [SADDR_W-1:0] ps_waddr, ps_raddr;
  logic [CNT_W-1:0]   ps_wdata, ps_rdata;

  ibma_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
  );

  ibma_ram #(.WIDTH(CNT_W), .DEPTH(ibma_pkg::STORE_D)) u_store (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
  );

  logic               in_acc;
  ibma_pkg::action_t  act;
  logic [BLK_W-1:0]   bidx;
  logic [CNT_W-1:0]   eff_span;
  logic [ROW_W:0]     nrows;
  logic [ROWS-1:0]    cand;
  logic [BIT_W:0]     cand_hit;
  logic [WORD_W-1:0]  row_word;
  logic [WORD_W-1:0]  row_mask;
  logic [WORD_W-1:0]  alloc_word;
  logic [BIT_W:0]     zero_hit;
  logic [WORD_W-1:0]  bit_onehot;
  logic [CNT_W-1:0]   n1, n2, n3;
  logic [SLOT_W-1:0]  lvl_slot;
  logic [CNT_W-1:0]   ev;
  logic [1:0]         dig_k;
  logic [DIG_W-1:0]   digit;
  logic [SADDR_W-1:0] next_ent;
  logic [CNT_W:0]     span_ext;

  assign in_tready = (state_r == ibma_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign act       = ibma_pkg::action_t'(in_tuser);
  assign bidx      = in_tdata[BLK_W-1:0];
  assign cfg_ready = 1'b1;

  assign eff_span = (span_r > CNT_W'(ibma_pkg::MAX_BLOCKS)) ?
                    CNT_W'(ibma_pkg::MAX_BLOCKS) : span_r;
  assign span_ext = {1'b0, eff_span} + (CNT_W+1)'(WORD_W - 1);
  assign nrows    = span_ext[CNT_W-1:BIT_W];

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      cand[r] = !rfull_r[r] && ((ROW_W+1)'(r) < nrows);
    end
  end
  assign cand_hit = ibma_pkg::lowest_zero(~cand);

  assign row_word = rvalid_r[row_r] ? bm_rdata : '0;
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      row_mask[b] = ({1'b0, row_r} == eff_span[CNT_W-1:BIT_W]) &&
                    (BIT_W'(b) >= eff_span[BIT_W-1:0]);
    end
  end
  assign alloc_word = row_word | row_mask;
  assign zero_hit   = ibma_pkg::lowest_zero(alloc_word);
  assign bit_onehot = WORD_W'(1) << (ibma_pkg::action_t'(ibma_pkg::ACT_NEW) == act ?
                      zero_hit[BIT_W-1:0] : zero_hit[BIT_W-1:0]);

  assign n1 = lc_r - CNT_W'(DIRECT);
  assign n2 = n1 - CNT_W'(PPB);
  assign n3 = n2 - CNT_W'(PPB * PPB);

  assign lvl_slot = SLOT_W'(DIRECT) + SLOT_W'(lvl_r) - SLOT_W'(1);
  assign ev       = src_st_r ? ps_rdata : slot_r[lvl_slot];
  assign dig_k    = lvl_r - 2'd1 - dep_r;
  assign digit    = off_r[dig_k*DIG_W +: DIG_W];
  assign next_ent = {blk_r, digit};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ibma_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (act)
            ibma_pkg::ACT_APPEND: begin
              state_nxt = (lc_r >= CNT_W'(ibma_pkg::MAP_CAP)) ?
                          ibma_pkg::S_DONE : ibma_pkg::S_ALLOC;
            end
            ibma_pkg::ACT_MARK: begin
              state_nxt = ({1'b0, bidx} >= eff_span) ?
                          ibma_pkg::S_DONE : ibma_pkg::S_MARK_RD;
            end
            default: state_nxt = ibma_pkg::S_DONE;
          endcase
        end
      end
      ibma_pkg::S_ALLOC: begin
        state_nxt = (free_r == '0 || !cand_hit[BIT_W]) ?
                    ibma_pkg::S_DONE : ibma_pkg::S_ALLOC_RD;
      end
      ibma_pkg::S_ALLOC_RD: begin
        if (!zero_hit[BIT_W]) begin
          state_nxt = ibma_pkg::S_DONE;
        end else if (ret_ptr_r) begin
          state_nxt = ibma_pkg::S_FILL;
        end else begin
          state_nxt = ibma_pkg::S_MAP;
        end
      end
      ibma_pkg::S_MAP: begin
        state_nxt = (lc_r < CNT_W'(DIRECT)) ? ibma_pkg::S_DONE : ibma_pkg::S_WCHK;
      end
      ibma_pkg::S_WCHK: begin
        state_nxt = (ev == ibma_pkg::EMPTY_MARK) ? ibma_pkg::S_ALLOC : ibma_pkg::S_WNEXT;
      end
      ibma_pkg::S_FILL: begin
        state_nxt = (cnt_r == DIG_W'(PPB - 1)) ? ibma_pkg::S_LINK : ibma_pkg::S_FILL;
      end
      ibma_pkg::S_LINK:  state_nxt = ibma_pkg::S_WNEXT;
      ibma_pkg::S_WNEXT: begin
        state_nxt = (dep_r + 2'd1 == lvl_r) ? ibma_pkg::S_FINAL : ibma_pkg::S_WCHK;
      end
      ibma_pkg::S_FINAL:   state_nxt = ibma_pkg::S_DONE;
      ibma_pkg::S_MARK_RD: state_nxt = ibma_pkg::S_DONE;
      ibma_pkg::S_DONE: begin
        if (!ov_r || out_tready) begin
          state_nxt = ibma_pkg::S_IDLE;
        end
      end
      default: state_nxt = ibma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    span_nxt    = span_r;
    free_nxt    = free_r;
    lc_nxt      = lc_r;
    slot_nxt    = slot_r;
    rvalid_nxt  = rvalid_r;
    rfull_nxt   = rfull_r;
    ret_ptr_nxt = ret_ptr_r;
    row_nxt     = row_r;
    mbit_nxt    = mbit_r;
    got_nxt     = got_r;
    data_nxt    = data_r;
    blk_nxt     = blk_r;
    lvl_nxt     = lvl_r;
    dep_nxt     = dep_r;
    off_nxt     = off_r;
    src_st_nxt  = src_st_r;
    ent_nxt     = ent_r;
    cnt_nxt     = cnt_r;
    rst_status_nxt = rst_status_r;
    rdata_blk_nxt  = rdata_blk_r;
    rlnum_nxt      = rlnum_r;
    ov_nxt      = ov_r;
    o_data_nxt  = o_data_r;
    o_lnum_nxt  = o_lnum_r;
    o_free_nxt  = o_free_r;
    o_stat_nxt  = o_stat_r;
    bm_we    = 1'b0;
    bm_waddr = row_r;
    bm_wdata = row_word | (WORD_W'(1) << mbit_r);
    bm_re    = 1'b0;
    bm_raddr = row_r;
    ps_we    = 1'b0;
    ps_waddr = ent_r;
    ps_wdata = ibma_pkg::EMPTY_MARK;
    ps_re    = 1'b0;
    ps_raddr = next_ent;

    if (out_tvalid && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ibma_pkg::S_IDLE: begin
        if (in_acc) begin
          rst_status_nxt = ibma_pkg::ST_OK;
          rdata_blk_nxt  = '0;
          rlnum_nxt      = '0;
          unique case (act)
            ibma_pkg::ACT_NEW: begin
              for (int s = 0; s < NSLOT; s++) begin
                slot_nxt[s] = ibma_pkg::EMPTY_MARK;
              end
              lc_nxt = '0;
            end
            ibma_pkg::ACT_APPEND: begin
              rlnum_nxt   = lc_r;
              ret_ptr_nxt = 1'b0;
              if (lc_r >= CNT_W'(ibma_pkg::MAP_CAP)) begin
                rst_status_nxt = ibma_pkg::ST_MAP_FULL;
              end
            end
            ibma_pkg::ACT_MARK: begin
              row_nxt  = bidx[BLK_W-1:BIT_W];
              mbit_nxt = bidx[BIT_W-1:0];
              bm_raddr = bidx[BLK_W-1:BIT_W];
              if ({1'b0, bidx} >= eff_span) begin
                rst_status_nxt = ibma_pkg::ST_BAD_PRELOAD;
              end else begin
                bm_re = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ibma_pkg::S_ALLOC: begin
        row_nxt  = cand_hit[BIT_W-1:0];
        bm_raddr = cand_hit[BIT_W-1:0];
        if (free_r == '0 || !cand_hit[BIT_W]) begin
          rst_status_nxt = ibma_pkg::ST_NO_FREE;
        end else begin
          bm_re = 1'b1;
        end
      end
      ibma_pkg::S_ALLOC_RD: begin
        if (!zero_hit[BIT_W]) begin
          rst_status_nxt = ibma_pkg::ST_NO_FREE;
        end else begin
          bm_we    = 1'b1;
          bm_wdata = row_word | bit_onehot;
          rvalid_nxt[row_r] = 1'b1;
          rfull_nxt[row_r]  = &(row_word | bit_onehot);
          free_nxt = free_r - CNT_W'(1);
          got_nxt  = {row_r, zero_hit[BIT_W-1:0]};
          cnt_nxt  = '0;
          if (!ret_ptr_r) begin
            data_nxt = {row_r, zero_hit[BIT_W-1:0]};
          end
        end
      end
      ibma_pkg::S_MAP: begin
        ret_ptr_nxt = 1'b1;
        dep_nxt     = '0;
        src_st_nxt  = 1'b0;
        if (lc_r < CNT_W'(DIRECT)) begin
          slot_nxt[lc_r[SLOT_W-1:0]] = {1'b0, data_r};
          rst_status_nxt = ibma_pkg::ST_OK;
          rdata_blk_nxt  = data_r;
          lc_nxt         = lc_r + CNT_W'(1);
        end else if (n1 < CNT_W'(PPB)) begin
          lvl_nxt = 2'd1;
          off_nxt = n1[OFF_W-1:0];
        end else if (n2 < CNT_W'(PPB * PPB)) begin
          lvl_nxt = 2'd2;
          off_nxt = n2[OFF_W-1:0];
        end else begin
          lvl_nxt = 2'd3;
          off_nxt = n3[OFF_W-1:0];
        end
      end
      ibma_pkg::S_WCHK: begin
        blk_nxt = ev[BLK_W-1:0];
      end
      ibma_pkg::S_FILL: begin
        ps_we    = 1'b1;
        ps_waddr = {got_r, cnt_r};
        ps_wdata = ibma_pkg::EMPTY_MARK;
        cnt_nxt  = cnt_r + DIG_W'(1);
      end
      ibma_pkg::S_LINK: begin
        blk_nxt = got_r;
        if (src_st_r) begin
          ps_we    = 1'b1;
          ps_waddr = ent_r;
          ps_wdata = {1'b0, got_r};
        end else begin
          slot_nxt[lvl_slot] = {1'b0, got_r};
        end
      end
      ibma_pkg::S_WNEXT: begin
        ent_nxt    = next_ent;
        dep_nxt    = dep_r + 2'd1;
        src_st_nxt = 1'b1;
        if (dep_r + 2'd1 != lvl_r) begin
          ps_re = 1'b1;
        end
      end
      ibma_pkg::S_FINAL: begin
        ps_we    = 1'b1;
        ps_waddr = ent_r;
        ps_wdata = {1'b0, data_r};
        rst_status_nxt = ibma_pkg::ST_OK;
        rdata_blk_nxt  = data_r;
        lc_nxt         = lc_r + CNT_W'(1);
      end
      ibma_pkg::S_MARK_RD: begin
        if (row_word[mbit_r]) begin
          rst_status_nxt = ibma_pkg::ST_BAD_PRELOAD;
        end else begin
          bm_we = 1'b1;
          rvalid_nxt[row_r] = 1'b1;
          rfull_nxt[row_r]  = &(row_word | (WORD_W'(1) << mbit_r));
          if (free_r != '0) begin
            free_nxt = free_r - CNT_W'(1);
          end
        end
      end
      ibma_pkg::S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt     = 1'b1;
          o_data_nxt = rdata_blk_r;
          o_lnum_nxt = rlnum_r;
          o_free_nxt = free_r;
          o_stat_nxt = rst_status_r;
        end
      end
      default: ;
    endcase

    if (cfg_valid && cfg_ready) begin
      span_nxt = cfg_data;
      free_nxt = (cfg_data > CNT_W'(ibma_pkg::MAX_BLOCKS)) ?
                 CNT_W'(ibma_pkg::MAX_BLOCKS) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ibma_pkg::S_IDLE;
      span_r   <= CNT_W'(ibma_pkg::MAX_BLOCKS);
      free_r   <= CNT_W'(ibma_pkg::MAX_BLOCKS);
      lc_r     <= '0;
      rvalid_r <= '0;
      rfull_r  <= '0;
      ov_r     <= 1'b0;
      for (int s = 0; s < NSLOT; s++) begin
        slot_r[s] <= ibma_pkg::EMPTY_MARK;
      end
    end else begin
      state_r  <= state_nxt;
      span_r   <= span_nxt;
      free_r   <= free_nxt;
      lc_r     <= lc_nxt;
      rvalid_r <= rvalid_nxt;
      rfull_r  <= rfull_nxt;
      ov_r     <= ov_nxt;
      slot_r   <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_ptr_r    <= ret_ptr_nxt;
    row_r        <= row_nxt;
    mbit_r       <= mbit_nxt;
    got_r        <= got_nxt;
    data_r       <= data_nxt;
    blk_r        <= blk_nxt;
    lvl_r        <= lvl_nxt;
    dep_r        <= dep_nxt;
    off_r        <= off_nxt;
    src_st_r     <= src_st_nxt;
    ent_r        <= ent_nxt;
    cnt_r        <= cnt_nxt;
    rst_status_r <= rst_status_nxt;
    rdata_blk_r  <= rdata_blk_nxt;
    rlnum_r      <= rlnum_nxt;
    o_data_r     <= o_data_nxt;
    o_lnum_r     <= o_lnum_nxt;
    o_free_r     <= o_free_nxt;
    o_stat_r     <= o_stat_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, o_free_r, o_lnum_r, o_data_r};
  assign out_tuser  = o_stat_r;

endmodule
`default_nettype wire

FILE: rtl/ibma_checker.sv
// Port-level checks for the indirect block map allocator, bound to the top.
// Depends on ibma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ibma_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:0] != 12'd0 |-> out_tuser == ibma_pkg::ST_OK)
    else $error("data block given with error status");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:25] <= 13'(ibma_pkg::MAX_BLOCKS))
    else $error("free count out of range");

  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind indirect_block_map_allocator ibma_checker u_ibma_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire

FILE: test/indirect_block_map_allocator_test.sv
// Testbench for indirect_block_map_allocator: drives new file, append, preload
// and no-op beats, predicts every result beat from its own bitmap and
// block map copy. Depends on ibma_pkg and the allocator RTL.
`timescale 1ns / 1ps
module indirect_block_map_allocator_test;
  import ibma_pkg::*;

  typedef struct {
    logic [11:0] data_block;
    logic [12:0] logical_number;
    status_t     status;
    logic [12:0] free_blocks;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = '0;

  indirect_block_map_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // allocator state copy
  bit          used_map [MAX_BLOCKS];
  int          free_left;
  int          search_span;
  int          ptr_table [MAX_BLOCKS * PTRS_PER_BLK];
  int          inode_map [INODE_SLOTS];
  int          file_length;

  alloc_result_t pending_results [$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("indirect_block_map_allocator test failed");
    $finish;
  end

  function automatic bit take_free_block(output int blk);
    if (free_left == 0) return 1'b0;
    for (int i = 0; i < search_span; i++) begin
      if (!used_map[i]) begin
        used_map[i] = 1'b1;
        free_left--;
        blk = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit record_mapping(input int lnum, input int data);
    int n, levels, stride, reach, slot, blk, fresh, ptr_addr;
    if (lnum < DIRECT_SLOTS) begin
      inode_map[lnum] = data;
      return 1'b1;
    end
    n = lnum - DIRECT_SLOTS;
    stride = 1;
    for (levels = 1; levels <= 3; levels++) begin
      reach = stride * PTRS_PER_BLK;
      if (n < reach) break;
      n -= reach;
      stride = reach;
    end
    if (levels > 3) return 1'b0;
    slot = DIRECT_SLOTS + levels - 1;
    ptr_addr = -1;
    for (int d = 0; d < levels; d++) begin
      blk = (ptr_addr < 0) ? inode_map[slot] : ptr_table[ptr_addr];
      if (blk == int'(EMPTY_MARK)) begin
        if (!take_free_block(fresh)) return 1'b0;
        for (int i = 0; i < PTRS_PER_BLK; i++) begin
          ptr_table[fresh * PTRS_PER_BLK + i] = int'(EMPTY_MARK);
        end
        if (ptr_addr < 0) inode_map[slot] = fresh;
        else ptr_table[ptr_addr] = fresh;
        blk = fresh;
      end
      ptr_addr = blk * PTRS_PER_BLK + (n / stride) % PTRS_PER_BLK;
      stride /= PTRS_PER_BLK;
    end
    ptr_table[ptr_addr] = data;
    return 1'b1;
  endfunction

  function automatic void predict_allocation(input action_t act, input int idx);
    alloc_result_t r;
    int blk;
    r.data_block = '0;
    r.logical_number = '0;
    r.status = ST_OK;
    case (act)
      ACT_NEW: begin
        for (int i = 0; i < INODE_SLOTS; i++) inode_map[i] = int'(EMPTY_MARK);
        file_length = 0;
      end
      ACT_APPEND: begin
        r.logical_number = 13'(file_length);
        if (file_length >= MAP_CAP) begin
          r.status = ST_MAP_FULL;
        end else if (!take_free_block(blk)) begin
          r.status = ST_NO_FREE;
        end else if (!record_mapping(file_length, blk)) begin
          r.status = ST_NO_FREE;
        end else begin
          r.data_block = 12'(blk);
          file_length++;
        end
      end
      ACT_MARK: begin
        if (idx >= search_span || used_map[idx]) begin
          r.status = ST_BAD_PRELOAD;
        end else begin
          used_map[idx] = 1'b1;
          if (free_left > 0) free_left--;
        end
      end
      default: ;
    endcase
    r.free_blocks = 13'(free_left);
    pending_results.insert(pending_results.size(), r);
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[11:0] !== e.data_block) begin
          $error("data_block expected %0d got %0d", e.data_block, out_tdata[11:0]);
          errors++;
        end
        if (out_tdata[24:12] !== e.logical_number) begin
          $error("logical_number expected %0d got %0d", e.logical_number, out_tdata[24:12]);
          errors++;
        end
        if (out_tuser !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_tuser);
          errors++;
        end
        if (out_tdata[37:25] !== e.free_blocks) begin
          $error("free_blocks expected %0d got %0d", e.free_blocks, out_tdata[37:25]);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_command(input action_t act, input logic [11:0] idx);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {4'b0, idx};
    do @(posedge clk); while (!in_tready);
    predict_allocation(act, idx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_span(input logic [12:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    search_span = (v > MAX_BLOCKS) ? MAX_BLOCKS : v;
    free_left = search_span;
  endtask

  task automatic test_directed();
    write_span(13'd4096);
    send_command(ACT_NEW, 12'hfff);
    repeat (3) send_command(ACT_APPEND, 12'h000);
    send_command(ACT_MARK, 12'hfff);
    send_command(ACT_MARK, 12'hfff);
    send_command(ACT_MARK, 12'h000);
    send_command(ACT_NOP, 12'hfff);
    send_command(ACT_NOP, 12'h000);
    write_span(13'd1);
    send_command(ACT_APPEND, 12'h000);
    send_command(ACT_MARK, 12'd4000);
    write_span(13'd0);
    send_command(ACT_APPEND, 12'h000);
    send_command(ACT_MARK, 12'h000);
    write_span(13'h1fff);
    send_command(ACT_APPEND, 12'h000);
    send_command(ACT_NEW, 12'h000);
    send_command(ACT_APPEND, 12'h555);
    send_command(ACT_MARK, 12'haaa);
    drain();
  endtask

  task automatic test_deep_map();
    send_command(ACT_NEW, 12'h000);
    repeat (320) send_command(ACT_APPEND, 12'($urandom));
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input logic [12:0] span);
    int pick;
    write_span(span);
    send_idle = idle;
    recv_stall = stall;
    repeat (290) begin
      pick = $urandom_range(99);
      if (pick < 8) send_command(ACT_NEW, 12'($urandom));
      else if (pick < 68) send_command(ACT_APPEND, 12'($urandom));
      else if (pick < 95) send_command(ACT_MARK, 12'($urandom));
      else send_command(ACT_NOP, 12'($urandom));
    end
    drain();
  endtask

  initial begin
    used_map = '{default: 1'b0};
    ptr_table = '{default: 0};
    inode_map = '{default: int'(EMPTY_MARK)};
    search_span = MAX_BLOCKS;
    free_left = MAX_BLOCKS;
    file_length = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_deep_map();
    test_random_phase(0, 0, 13'd4096);
    test_random_phase(77, 0, 13'h1fff);
    test_random_phase(0, 77, 13'(3000 + $urandom_range(1096)));
    test_random_phase(14, 14, 13'd4096);
    test_random_phase(0, 0, 13'd700);
    if (errors == 0) begin
      $display("indirect_block_map_allocator test passed");
    end else begin
      $display("indirect_block_map_allocator test failed");
    end
    $finish;
  end

endmodule
